@@ design/sdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdcd_pkg
// Shared constants, payload types and stage records for the serial day to
// calendar date converter.
// ----------------------------------------------------------------------------
package sdcd_pkg;

  // pipeline shape: front stage, day split stages, month stage
  localparam int DayStages  = 6;
  localparam int TimeStages = 7;
  localparam int NumStages  = DayStages + 2;

  localparam int DaysWidth = 23;
  localparam int SecWidth  = 17;
  localparam int AbsWidth  = 22;

  localparam int DayMin       = -657434;
  localparam int DayMax       = 2958465;
  localparam int DaysToEpoch  = 693959;
  localparam int DaysPer400   = 146097;
  localparam int DaysPerCent  = 36524;
  localparam int DaysPer4y    = 1461;
  localparam int DaysPerYear  = 365;
  localparam int DaysPerWeek  = 7;
  localparam int WdayOffset   = 6;    // day 0 of year 0 was a Saturday
  localparam int LastSecond   = 86399;
  localparam int SecPerHour   = 3600;
  localparam int SecPerMin    = 60;
  localparam int MonthsPerYear = 12;
  localparam int LeapDayIdx   = 59;   // zero-based day of year of Feb 29

  // floor reciprocals; the quotient estimate is low by at most one
  localparam int Div400Shift = 22;
  localparam int Div400Mul   = (1 << Div400Shift) / DaysPer400;
  localparam int Div7Shift   = 22;
  localparam int Div7Mul     = (1 << Div7Shift) / DaysPerWeek;
  localparam int Div4yShift  = 16;
  localparam int Div4yMul    = (1 << Div4yShift) / DaysPer4y;
  localparam int HourShift   = 17;
  localparam int HourMul     = (1 << HourShift) / SecPerHour;
  localparam int MinShift    = 12;
  localparam int MinMul      = (1 << MinShift) / SecPerMin;

  localparam logic [8:0] CumDays [13] =
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243,
        9'd273, 9'd304, 9'd334, 9'd365};

  typedef struct packed {
    logic signed [22:0] serial_days;
    logic [16:0]        second_of_day;
  } sdcd_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } sdcd_out_t;

  typedef struct packed {
    logic        vres;
    logic [21:0] abs_day;
    logic [16:0] secs;
  } sdcd_front_t;

  typedef struct packed {
    logic        vres;
    logic [13:0] year;
    logic [8:0]  yday;
    logic [8:0]  dd;       // zero-based day of year
    logic        leap_yr;
    logic [2:0]  wday;
  } sdcd_date_t;

  typedef struct packed {
    logic        vres;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [2:0]  wday;
    logic [8:0]  yday;
  } sdcd_cal_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } sdcd_tod_t;

endpackage

@@ design/serial_day_to_calendar_date.sv @@
// ----------------------------------------------------------------------------
// serial_day_to_calendar_date
// Serial day count plus second of day to calendar date and time of day.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: serial_days (signed days from 30 Dec 1899) and second_of_day.
//   Output beat: valid_res, year, month, day_of_month, weekday (0 = Sunday),
//   day_of_year, hour, minute, second. A day outside -657434..2958465 gives
//   valid_res low and all other fields zero; second_of_day above 86399 is
//   clamped to 23:59:59.
//   Both channels are valid/stall; a beat moves when valid is high and stall
//   is low.
//   One beat per cycle is sustained while the receiver does not stall. The
//   depth is set by the reciprocal divides (estimate stage, correction
//   stage) for 400-year, 4-year, weekday, hour, minute.
//   Each stage has its own valid bit, so bubbles are squeezed out when the
//   receiver stalls; in_stall_o rises only once all 8 stages hold beats.
//   Reset clears the valid bits only; nothing is in flight after reset.
// ----------------------------------------------------------------------------
module serial_day_to_calendar_date (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sdcd_pkg::sdcd_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdcd_pkg::sdcd_out_t  out_data_o
);
  import sdcd_pkg::*;

  logic [NumStages-1:0] v_q, en;
  sdcd_front_t          front;
  sdcd_date_t           date;
  sdcd_cal_t            cal;
  sdcd_tod_t            tod;

  // a stage loads when it is empty or the stage after it loads
  assign en[NumStages-1] = ~v_q[NumStages-1] | ~out_stall_i;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = ~v_q[k] | en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (v_q & ~en) | ({v_q[NumStages-2:0], in_valid_i} & en);
    end
  end

  sdcd_front u_front (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .data_i  (in_data_i),
    .front_o (front)
  );

  sdcd_day_split u_day (
    .clk_i   (clk_i),
    .en_i    (en[DayStages:1]),
    .front_i (front),
    .date_o  (date)
  );

  sdcd_month_find u_month (
    .clk_i  (clk_i),
    .en_i   (en[NumStages-1]),
    .date_i (date),
    .cal_o  (cal)
  );

  sdcd_time_split u_time (
    .clk_i  (clk_i),
    .en_i   (en[TimeStages:1]),
    .secs_i (front.secs),
    .tod_o  (tod)
  );

  assign in_stall_o  = ~en[0];
  assign out_valid_o = v_q[NumStages-1];

  // out-of-range days report zeros in every field
  always_comb begin
    out_data_o.valid_res    = cal.vres;
    out_data_o.year         = cal.vres ? cal.year  : '0;
    out_data_o.month        = cal.vres ? cal.month : '0;
    out_data_o.day_of_month = cal.vres ? cal.mday  : '0;
    out_data_o.weekday      = cal.vres ? cal.wday  : '0;
    out_data_o.day_of_year  = cal.vres ? cal.yday  : '0;
    out_data_o.hour         = cal.vres ? tod.hour   : '0;
    out_data_o.minute       = cal.vres ? tod.minute : '0;
    out_data_o.second       = cal.vres ? tod.second : '0;
  end

endmodule

@@ design/sdcd_front.sv @@
// ----------------------------------------------------------------------------
// sdcd_front
// Input stage: range check, shift of the day count to year 0, clamp of the
// second of day.
// ----------------------------------------------------------------------------
module sdcd_front (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  sdcd_pkg::sdcd_in_t     data_i,
  output sdcd_pkg::sdcd_front_t  front_o
);
  import sdcd_pkg::*;

  localparam logic signed [DaysWidth-1:0] DayLo   = DaysWidth'(DayMin);
  localparam logic signed [DaysWidth-1:0] DayHi   = DaysWidth'(DayMax);
  localparam logic signed [DaysWidth-1:0] EpochSh = DaysWidth'(DaysToEpoch);

  logic signed [DaysWidth-1:0] sum;
  sdcd_front_t                 front_d, front_q;

  always_comb begin
    sum             = data_i.serial_days + EpochSh;
    front_d.vres    = (data_i.serial_days >= DayLo) && (data_i.serial_days <= DayHi);
    front_d.abs_day = sum[AbsWidth-1:0];
    front_d.secs    = (data_i.second_of_day > SecWidth'(LastSecond)) ?
                      SecWidth'(LastSecond) : data_i.second_of_day;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule

@@ design/sdcd_day_split.sv @@
// ----------------------------------------------------------------------------
// sdcd_day_split
// Six stages: 400-year, century, 4-year and year split of the day count,
// weekday, year number and day of year.
// ----------------------------------------------------------------------------
module sdcd_day_split (
  input  logic                          clk_i,
  input  logic [sdcd_pkg::DayStages-1:0] en_i,
  input  sdcd_pkg::sdcd_front_t         front_i,
  output sdcd_pkg::sdcd_date_t          date_o
);
  import sdcd_pkg::*;

  // stage 2: reciprocal estimates
  logic [21:0] wx;
  logic [26:0] p400;
  logic [41:0] pw;
  logic        vres2_q;
  logic [21:0] abs2_q, wx2_q;
  logic [4:0]  qa2_q;
  logic [19:0] wq2_q;

  always_comb begin
    wx   = front_i.abs_day + 22'(WdayOffset);
    p400 = 27'(front_i.abs_day) * 27'(Div400Mul);
    pw   = 42'(wx) * 42'(Div7Mul);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      vres2_q <= front_i.vres;
      abs2_q  <= front_i.abs_day;
      wx2_q   <= wx;
      qa2_q   <= p400[Div400Shift+4:Div400Shift];
      wq2_q   <= pw[Div7Shift+19:Div7Shift];
    end
  end

  // stage 3: quotient corrections
  logic [21:0] p3, wr;
  logic        ge3;
  logic [3:0]  w4;
  logic        vres3_q;
  logic [4:0]  n400_3_q;
  logic [17:0] r400_3_q;
  logic [2:0]  wday3_q;

  always_comb begin
    p3  = abs2_q - 22'(qa2_q) * 22'(DaysPer400);
    ge3 = p3 >= 22'(DaysPer400);
    wr  = wx2_q - 22'(wq2_q) * 22'(DaysPerWeek);
    w4  = wr[3:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      vres3_q  <= vres2_q;
      n400_3_q <= ge3 ? qa2_q + 5'd1 : qa2_q;
      r400_3_q <= ge3 ? 18'(p3 - 22'(DaysPer400)) : 18'(p3);
      wday3_q  <= (w4 >= 4'(DaysPerWeek)) ? 3'(w4 - 4'(DaysPerWeek)) : 3'(w4);
    end
  end

  // stage 4: century by compare ladder
  logic [17:0] t4, a4;
  logic [1:0]  cent;
  logic [15:0] x4;
  logic        vres4_q;
  logic [4:0]  n400_4_q;
  logic [1:0]  cent4_q;
  logic [15:0] x4_q;
  logic [2:0]  wday4_q;

  always_comb begin
    t4 = r400_3_q - 18'd1;
    priority if (r400_3_q == '0)                 cent = 2'd0;
    else if (t4 >= 18'(3 * DaysPerCent))         cent = 2'd3;
    else if (t4 >= 18'(2 * DaysPerCent))         cent = 2'd2;
    else if (t4 >= 18'(DaysPerCent))             cent = 2'd1;
    else                                         cent = 2'd0;
    a4 = t4 - 18'(cent) * 18'(DaysPerCent);
    x4 = (cent != 2'd0) ? 16'(a4 + 18'd1) : 16'(r400_3_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      vres4_q  <= vres3_q;
      n400_4_q <= n400_3_q;
      cent4_q  <= cent;
      x4_q     <= x4;
      wday4_q  <= wday3_q;
    end
  end

  // stage 5: 4-year estimate
  logic [21:0] p4y;
  logic        vres5_q;
  logic [4:0]  n400_5_q, q5_q;
  logic [1:0]  cent5_q;
  logic [15:0] x5_q;
  logic [2:0]  wday5_q;

  assign p4y = 22'(x4_q) * 22'(Div4yMul);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      vres5_q  <= vres4_q;
      n400_5_q <= n400_4_q;
      cent5_q  <= cent4_q;
      x5_q     <= x4_q;
      q5_q     <= p4y[Div4yShift+4:Div4yShift];
      wday5_q  <= wday4_q;
    end
  end

  // stage 6: 4-year correction; block 0 of centuries 1..3 has no leap day
  logic [15:0] r6, r6c;
  logic        ge6, leap6;
  logic [4:0]  n4;
  logic        vres6_q, leap6_q;
  logic [4:0]  n400_6_q, n4_6_q;
  logic [1:0]  cent6_q;
  logic [10:0] d4_6_q;
  logic [2:0]  wday6_q;

  always_comb begin
    r6    = x5_q - 16'(q5_q) * 16'(DaysPer4y);
    ge6   = r6 >= 16'(DaysPer4y);
    n4    = ge6 ? q5_q + 5'd1 : q5_q;
    r6c   = ge6 ? r6 - 16'(DaysPer4y) : r6;
    leap6 = !((cent5_q != 2'd0) && (n4 == 5'd0));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      vres6_q  <= vres5_q;
      n400_6_q <= n400_5_q;
      cent6_q  <= cent5_q;
      n4_6_q   <= n4;
      leap6_q  <= leap6;
      d4_6_q   <= leap6 ? 11'(r6c) : 11'(r6c - 16'd1);
      wday6_q  <= wday5_q;
    end
  end

  // stage 7: year within the 4-year block, year number
  logic [10:0] t7, base7, dd7;
  logic [1:0]  y4;
  sdcd_date_t  date_d, date_q;

  always_comb begin
    t7    = leap6_q ? d4_6_q - 11'd1 : d4_6_q;
    priority if (leap6_q && (d4_6_q == '0))      y4 = 2'd0;
    else if (t7 >= 11'(3 * DaysPerYear))         y4 = 2'd3;
    else if (t7 >= 11'(2 * DaysPerYear))         y4 = 2'd2;
    else if (t7 >= 11'(DaysPerYear))             y4 = 2'd1;
    else                                         y4 = 2'd0;
    base7 = 11'(y4) * 11'(DaysPerYear);
    dd7   = (leap6_q && (y4 == 2'd0)) ? d4_6_q : t7 - base7;

    date_d.vres    = vres6_q;
    date_d.dd      = 9'(dd7);
    date_d.yday    = 9'(dd7 + 11'd1);
    date_d.leap_yr = leap6_q && (y4 == 2'd0);
    date_d.wday    = wday6_q;
    date_d.year    = 14'(n400_6_q) * 14'd400 + 14'(cent6_q) * 14'd100
                   + 14'(n4_6_q) * 14'd4 + 14'(y4);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      date_q <= date_d;
    end
  end

  assign date_o = date_q;

endmodule

@@ design/sdcd_time_split.sv @@
// ----------------------------------------------------------------------------
// sdcd_time_split
// Second of day to hour, minute and second, then delay to line up with
// the date path.
// ----------------------------------------------------------------------------
module sdcd_time_split (
  input  logic                            clk_i,
  input  logic [sdcd_pkg::TimeStages-1:0] en_i,
  input  logic [16:0]                     secs_i,
  output sdcd_pkg::sdcd_tod_t             tod_o
);
  import sdcd_pkg::*;

  // hour estimate
  logic [22:0] ph;
  logic [16:0] secs2_q;
  logic [4:0]  hq2_q;

  assign ph = 23'(secs_i) * 23'(HourMul);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      secs2_q <= secs_i;
      hq2_q   <= ph[HourShift+4:HourShift];
    end
  end

  // hour correction
  logic [16:0] r3;
  logic        ge3;
  logic [4:0]  h3_q;
  logic [11:0] rh3_q;

  always_comb begin
    r3  = secs2_q - 17'(hq2_q) * 17'(SecPerHour);
    ge3 = r3 >= 17'(SecPerHour);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      h3_q  <= ge3 ? hq2_q + 5'd1 : hq2_q;
      rh3_q <= ge3 ? 12'(r3 - 17'(SecPerHour)) : 12'(r3);
    end
  end

  // minute estimate
  logic [18:0] pm;
  logic [4:0]  h4_q;
  logic [11:0] rh4_q;
  logic [5:0]  mq4_q;

  assign pm = 19'(rh3_q) * 19'(MinMul);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      h4_q  <= h3_q;
      rh4_q <= rh3_q;
      mq4_q <= pm[MinShift+5:MinShift];
    end
  end

  // minute correction, then a delay line to the output stage
  localparam int DelayLen = TimeStages - 3;

  logic [11:0] r5;
  logic        ge5;
  sdcd_tod_t   tod5;
  sdcd_tod_t   tod_q [DelayLen];

  always_comb begin
    r5          = rh4_q - 12'(mq4_q) * 12'(SecPerMin);
    ge5         = r5 >= 12'(SecPerMin);
    tod5.hour   = h4_q;
    tod5.minute = ge5 ? mq4_q + 6'd1 : mq4_q;
    tod5.second = ge5 ? 6'(r5 - 12'(SecPerMin)) : 6'(r5);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      tod_q[0] <= tod5;
    end
  end

  for (genvar k = 1; k < DelayLen; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en_i[3+k]) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  assign tod_o = tod_q[DelayLen-1];

endmodule

@@ design/sdcd_month_find.sv @@
// ----------------------------------------------------------------------------
// sdcd_month_find
// Output stage of the date path: month and day of month from the day of
// year, Feb 29 handled on its own.
// ----------------------------------------------------------------------------
module sdcd_month_find (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  sdcd_pkg::sdcd_date_t date_i,
  output sdcd_pkg::sdcd_cal_t  cal_o
);
  import sdcd_pkg::*;

  logic [8:0] d;
  logic [3:0] cnt;
  logic       is_feb29;
  sdcd_cal_t  cal_d, cal_q;

  always_comb begin
    is_feb29 = date_i.leap_yr && (date_i.dd == 9'(LeapDayIdx));
    // past Feb 29 the leap day is dropped so the common table applies
    d = (date_i.leap_yr && (date_i.dd > 9'(LeapDayIdx))) ? date_i.dd : date_i.dd + 9'd1;
    cnt = '0;
    for (int k = 1; k < MonthsPerYear; k++) begin
      if (d > CumDays[4'(k)]) cnt = cnt + 4'd1;
    end

    cal_d.vres = date_i.vres;
    cal_d.year = date_i.year;
    cal_d.wday = date_i.wday;
    cal_d.yday = date_i.yday;
    if (is_feb29) begin
      cal_d.month = 4'd2;
      cal_d.mday  = 5'd29;
    end else begin
      cal_d.month = cnt + 4'd1;
      cal_d.mday  = 5'(d - CumDays[cnt]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule

@@ design/sdcd_checker.sv @@
// ----------------------------------------------------------------------------
// sdcd_checker
// Port-level checks for the serial day to calendar date converter.
// ----------------------------------------------------------------------------
module sdcd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sdcd_pkg::sdcd_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sdcd_pkg::sdcd_out_t out_data_o
);
  import sdcd_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // input backs up only when the output side is full and stalled
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_data_o.valid_res |->
        out_data_o.year == '0 && out_data_o.month == '0 &&
        out_data_o.day_of_month == '0 && out_data_o.weekday == '0 &&
        out_data_o.day_of_year == '0 && out_data_o.hour == '0 &&
        out_data_o.minute == '0 && out_data_o.second == '0)
    else $error("out-of-range beat has nonzero fields");

  a_fields_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_data_o.valid_res |->
        out_data_o.month >= 4'd1 && out_data_o.month <= 4'd12 &&
        out_data_o.day_of_month >= 5'd1 && out_data_o.weekday <= 3'd6 &&
        out_data_o.hour <= 5'd23 && out_data_o.minute <= 6'd59 &&
        out_data_o.second <= 6'd59)
    else $error("calendar field out of range");

  // January days map one to one onto days of year
  a_jan_yday: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_data_o.valid_res && out_data_o.month == 4'd1 |->
        out_data_o.day_of_year == 9'(out_data_o.day_of_month))
    else $error("day of year disagrees with January date");

endmodule

bind serial_day_to_calendar_date sdcd_checker u_sdcd_checker (.*);
